@@ hw/rtl/column_classify_dedup_macros.svh @@
// Assertion macros for the column classifier.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef COLUMN_CLASSIFY_DEDUP_MACROS_SVH
`define COLUMN_CLASSIFY_DEDUP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CCD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ccd_pkg.sv @@
// Shared types and constants of the column classifier.
// No dependencies; the interfaces, top level, row merge and id scan use it.
package ccd_pkg;

    localparam int ROWS_MAX_DEF     = 64;
    localparam int PATTERNS_MAX_DEF = 64;
    localparam int COLS_MAX_DEF     = 1024;

    localparam int ENTRY_W    = 5;
    localparam int ROWS_CFG_W = 7;
    localparam int COL_IDX_W  = 10;
    localparam int CLASS_W    = 2;
    localparam int ROW_OUT_W  = 6;
    localparam int ID_OUT_W   = 6;

    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 7'd64;

    localparam logic [ENTRY_W-1:0] ENTRY_ZERO = 5'd0;
    localparam logic [ENTRY_W-1:0] ENTRY_ONE  = 5'd1;

    // Flags checked per cycle by the id scanner, a power of two.
    localparam int SCAN_GROUP = 16;
    localparam int SCAN_ID_W  = 10;

    typedef enum logic [CLASS_W-1:0] {
        CLS_ZERO     = 2'd0,
        CLS_ONE      = 2'd1,
        CLS_SINGLE   = 2'd2,
        CLS_DISTINCT = 2'd3
    } t_class;

    typedef struct packed {
        logic                 done;
        logic                 found;
        logic [SCAN_ID_W-1:0] id;
    } t_scan_res;

endpackage

@@ hw/rtl/ccd_if.sv @@
// Channel interfaces of the column classifier: entries, results, row count.
// Depends on ccd_pkg for field widths.
interface ccd_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [ccd_pkg::ENTRY_W-1:0] entry_value;
    logic                               new_matrix;

    modport source (output valid, entry_value, new_matrix, input ready);
    modport sink   (input valid, entry_value, new_matrix, output ready);
endinterface

interface ccd_out_if;
    logic                           valid;
    logic                           ready;
    logic [ccd_pkg::COL_IDX_W-1:0]  column_index;
    logic [ccd_pkg::CLASS_W-1:0]    column_class;
    logic [ccd_pkg::ROW_OUT_W-1:0]  single_one_row;
    logic [ccd_pkg::ID_OUT_W-1:0]   pattern_id;
    logic                           table_full;

    modport source (output valid, column_index, column_class, single_one_row, pattern_id,
                    table_full, input ready);
    modport sink   (input valid, column_index, column_class, single_one_row, pattern_id,
                    table_full, output ready);
endinterface

interface ccd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ccd_pkg::ROWS_CFG_W-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ hw/rtl/column_classify_dedup.sv @@
// Column classifier with duplicate-pattern detection, top level.
// Depends on ccd_pkg, ccd_if, ccd_ram, ccd_row_merge, ccd_id_scan and the macro header.
//
//  channel  dir  payload                                         transfer when
//  i_in     in   entry_value, new_matrix                         valid && ready
//  o_res    out  column_index, column_class, single_one_row,     valid && ready
//                pattern_id, table_full
//  i_cfg    in   data (rows_in_use)                              valid && ready
//
// An entry is handled as a read of its row of the pattern store, then compare and write back,
// and a new entry is taken only after that. A column's last entry then goes to S_OUT, and a
// distinct pattern first goes through an id scan over the stored patterns' mismatch flags.
// A result waiting in the output register holds the next column end until it is taken.
// Synchronous active-low reset; the pattern store needs no clearing and is ready at once.
`include "column_classify_dedup_macros.svh"

module column_classify_dedup #(
    parameter int ROWS_MAX     = ccd_pkg::ROWS_MAX_DEF,
    parameter int PATTERNS_MAX = ccd_pkg::PATTERNS_MAX_DEF,
    parameter int COLS_MAX     = ccd_pkg::COLS_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ccd_in_if.sink           i_in,
    ccd_out_if.source        o_res,
    ccd_cfg_if.sink          i_cfg
);
    import ccd_pkg::*;

    localparam int RW  = $clog2(ROWS_MAX);
    localparam int RCW = $clog2(ROWS_MAX + 1);
    localparam int SW  = $clog2(PATTERNS_MAX + 1);
    localparam int IDW = $clog2(PATTERNS_MAX);
    localparam int CW  = $clog2(COLS_MAX);
    localparam int MW  = PATTERNS_MAX * ENTRY_W;
    localparam int XW  = (RCW > ROWS_CFG_W) ? RCW : ROWS_CFG_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_SCAN = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    // control state
    t_state                  r_state,  n_state;
    logic [ROWS_CFG_W-1:0]   r_rows;
    logic [RW-1:0]           r_row,    n_row;
    logic [RCW-1:0]          r_zero,   n_zero;
    logic [RCW-1:0]          r_one,    n_one;
    logic [RCW-1:0]          r_miss,   n_miss;
    logic [RW-1:0]           r_lone,   n_lone;
    logic [CW-1:0]           r_col,    n_col;
    logic [SW-1:0]           r_stored, n_stored;
    logic [PATTERNS_MAX-1:0] r_flags,  n_flags;
    logic                    r_last,   n_last;
    logic                    r_out_valid, n_out_valid;

    // payload
    logic [RW-1:0]           r_cur_row, n_cur_row;
    logic [ENTRY_W-1:0]      r_v,       n_v;
    t_class                  r_cls,     n_cls;
    logic [RW-1:0]           r_lone_out, n_lone_out;
    logic [IDW-1:0]          r_id,      n_id;
    logic                    r_full,    n_full;
    logic [COL_IDX_W-1:0]    r_out_col, n_out_col;
    logic [CLASS_W-1:0]      r_out_cls, n_out_cls;
    logic [ROW_OUT_W-1:0]    r_out_row, n_out_row;
    logic [ID_OUT_W-1:0]     r_out_id,  n_out_id;
    logic                    r_out_full, n_out_full;

    logic                    w_in_xfer;
    logic                    w_out_xfer;
    logic [RCW-1:0]          w_rows_eff;
    logic [ENTRY_W-1:0]      w_v_in;
    logic [RW-1:0]           w_row_base;
    logic [RCW-1:0]          w_taken;
    logic                    w_is_zero;
    logic                    w_is_one;
    logic                    w_is_single;
    logic [MW-1:0]           w_rd_row;
    logic [MW-1:0]           w_wr_row;
    logic [PATTERNS_MAX-1:0] w_m_flags;
    logic                    w_scan_start;
    t_scan_res               w_scan;

    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_xfer = o_res.valid && o_res.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        if (r_rows == '0) begin
            w_rows_eff = RCW'(1);
        end else if (XW'(r_rows) > XW'(ROWS_MAX)) begin
            w_rows_eff = RCW'(ROWS_MAX);
        end else begin
            w_rows_eff = RCW'(r_rows);
        end
    end

    assign w_v_in     = $unsigned(i_in.entry_value);
    assign w_row_base = i_in.new_matrix ? '0 : r_row;

    assign w_taken     = RCW'(r_cur_row) + RCW'(1);
    assign w_is_zero   = ({1'b0, r_zero} + {1'b0, r_miss}) == {1'b0, w_taken};
    assign w_is_one    = ({1'b0, r_one} + {1'b0, r_miss}) == {1'b0, w_taken};
    assign w_is_single = (r_one == RCW'(1));

    assign w_scan_start = (r_state == S_CMP) && r_last && !w_is_zero && !w_is_one
                          && !w_is_single;

    ccd_ram #(
        .WIDTH (MW),
        .DEPTH (ROWS_MAX)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_state == S_CMP),
        .i_waddr (r_cur_row),
        .i_wdata (w_wr_row),
        .i_re    (w_in_xfer),
        .i_raddr (w_row_base),
        .o_rdata (w_rd_row)
    );

    ccd_row_merge #(
        .PATTERNS_MAX (PATTERNS_MAX)
    ) u_merge (
        .i_rd_row (w_rd_row),
        .i_v      (r_v),
        .i_stored (r_stored),
        .i_flags  (r_flags),
        .o_flags  (w_m_flags),
        .o_wr_row (w_wr_row)
    );

    ccd_id_scan #(
        .PATTERNS_MAX (PATTERNS_MAX)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_scan_start),
        .i_flags  (r_flags),
        .i_stored (r_stored),
        .o_res    (w_scan)
    );

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_zero      = r_zero;
        n_one       = r_one;
        n_miss      = r_miss;
        n_lone      = r_lone;
        n_col       = r_col;
        n_stored    = r_stored;
        n_flags     = r_flags;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_cur_row   = r_cur_row;
        n_v         = r_v;
        n_cls       = r_cls;
        n_lone_out  = r_lone_out;
        n_id        = r_id;
        n_full      = r_full;
        n_out_col   = r_out_col;
        n_out_cls   = r_out_cls;
        n_out_row   = r_out_row;
        n_out_id    = r_out_id;
        n_out_full  = r_out_full;

        if (w_out_xfer) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    // A new matrix drops any partial column and empties the store.
                    n_zero  = i_in.new_matrix ? '0 : r_zero;
                    n_one   = i_in.new_matrix ? '0 : r_one;
                    n_miss  = i_in.new_matrix ? '0 : r_miss;
                    n_lone  = i_in.new_matrix ? '0 : r_lone;
                    n_flags = i_in.new_matrix ? '0 : r_flags;
                    if (i_in.new_matrix) begin
                        n_col    = '0;
                        n_stored = '0;
                    end
                    if (w_v_in == ENTRY_ZERO) begin
                        n_zero = n_zero + RCW'(1);
                    end else if (w_v_in == ENTRY_ONE) begin
                        n_one  = n_one + RCW'(1);
                        n_lone = w_row_base;
                    end else begin
                        n_miss = n_miss + RCW'(1);
                    end
                    n_cur_row = w_row_base;
                    n_v       = w_v_in;
                    n_last    = (RCW'(w_row_base) + RCW'(1)) >= w_rows_eff;
                    n_row     = n_last ? '0 : (w_row_base + RW'(1));
                    n_state   = S_CMP;
                end
            end
            S_CMP: begin
                n_flags    = w_m_flags;
                n_id       = '0;
                n_full     = 1'b0;
                n_lone_out = '0;
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (w_is_zero) begin
                    n_cls   = CLS_ZERO;
                    n_state = S_OUT;
                end else if (w_is_one) begin
                    n_cls   = CLS_ONE;
                    n_state = S_OUT;
                end else if (w_is_single) begin
                    n_cls      = CLS_SINGLE;
                    n_lone_out = r_lone;
                    n_state    = S_OUT;
                end else begin
                    n_cls   = CLS_DISTINCT;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_scan.done) begin
                    if (w_scan.found) begin
                        n_id = IDW'(w_scan.id);
                    end else if (r_stored < SW'(PATTERNS_MAX)) begin
                        // Unseen pattern: keep the slot it was written into.
                        n_id     = IDW'(r_stored);
                        n_stored = r_stored + SW'(1);
                    end else begin
                        n_full = 1'b1;
                    end
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_col   = COL_IDX_W'(r_col);
                    n_out_cls   = r_cls;
                    n_out_row   = ROW_OUT_W'(r_lone_out);
                    n_out_id    = ID_OUT_W'(r_id);
                    n_out_full  = r_full;
                    n_col       = (r_col == CW'(COLS_MAX - 1)) ? '0 : (r_col + CW'(1));
                    n_row       = '0;
                    n_zero      = '0;
                    n_one       = '0;
                    n_miss      = '0;
                    n_lone      = '0;
                    n_flags     = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rows      <= ROWS_RESET;
            r_row       <= '0;
            r_zero      <= '0;
            r_one       <= '0;
            r_miss      <= '0;
            r_lone      <= '0;
            r_col       <= '0;
            r_stored    <= '0;
            r_flags     <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_zero      <= n_zero;
            r_one       <= n_one;
            r_miss      <= n_miss;
            r_lone      <= n_lone;
            r_col       <= n_col;
            r_stored    <= n_stored;
            r_flags     <= n_flags;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_rows <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_row  <= n_cur_row;
        r_v        <= n_v;
        r_cls      <= n_cls;
        r_lone_out <= n_lone_out;
        r_id       <= n_id;
        r_full     <= n_full;
        r_out_col  <= n_out_col;
        r_out_cls  <= n_out_cls;
        r_out_row  <= n_out_row;
        r_out_id   <= n_out_id;
        r_out_full <= n_out_full;
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.column_index   = r_out_col;
    assign o_res.column_class   = r_out_cls;
    assign o_res.single_one_row = r_out_row;
    assign o_res.pattern_id     = r_out_id;
    assign o_res.table_full     = r_out_full;

    `CCD_ASSERT_IMP(a_out_src, $rose(r_out_valid), $past(r_state == S_OUT), "stray result")
    `CCD_ASSERT_IMP(a_full_cls, r_out_valid && r_out_full, r_out_cls == CLS_DISTINCT, "bad full")
    `CCD_ASSERT_NXT(a_accept_cmp, w_in_xfer, r_state == S_CMP, "no compare step")
    `CCD_ASSERT_IMP(a_scan_in_state, w_scan.done, r_state == S_SCAN, "scan done outside scan")
endmodule

@@ hw/rtl/ccd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ccd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ hw/rtl/ccd_row_merge.sv @@
// Compares one entry against a row of all stored patterns and builds the write-back row.
// Depends on ccd_pkg.
module ccd_row_merge #(
    parameter int PATTERNS_MAX = ccd_pkg::PATTERNS_MAX_DEF
) (
    input  logic [PATTERNS_MAX*ccd_pkg::ENTRY_W-1:0] i_rd_row,
    input  logic [ccd_pkg::ENTRY_W-1:0]              i_v,
    input  logic [$clog2(PATTERNS_MAX+1)-1:0]        i_stored,
    input  logic [PATTERNS_MAX-1:0]                  i_flags,
    output logic [PATTERNS_MAX-1:0]                  o_flags,
    output logic [PATTERNS_MAX*ccd_pkg::ENTRY_W-1:0] o_wr_row
);
    import ccd_pkg::*;

    localparam int SW = $clog2(PATTERNS_MAX + 1);

    always_comb begin
        for (int p = 0; p < PATTERNS_MAX; p++) begin
            // Only live patterns can mismatch; the slot at the fill point takes the entry.
            o_flags[p] = i_flags[p] ||
                         ((SW'(p) < i_stored) && (i_rd_row[p*ENTRY_W +: ENTRY_W] != i_v));
            o_wr_row[p*ENTRY_W +: ENTRY_W] = (SW'(p) == i_stored) ? i_v
                                             : i_rd_row[p*ENTRY_W +: ENTRY_W];
        end
    end
endmodule

@@ hw/rtl/ccd_id_scan.sv @@
// Finds the first live pattern without a mismatch, one group of flags per cycle.
// Depends on ccd_pkg.
module ccd_id_scan #(
    parameter int PATTERNS_MAX = ccd_pkg::PATTERNS_MAX_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [PATTERNS_MAX-1:0]           i_flags,
    input  logic [$clog2(PATTERNS_MAX+1)-1:0] i_stored,
    output ccd_pkg::t_scan_res                o_res
);
    import ccd_pkg::*;

    localparam int G    = SCAN_GROUP;
    localparam int GB   = $clog2(G);
    localparam int NG   = (PATTERNS_MAX + G - 1) / G;
    localparam int PADW = NG * G;
    localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
    localparam int IW   = $clog2(PADW);
    localparam int SW   = $clog2(PATTERNS_MAX + 1);
    localparam int CMW  = (IW > SW) ? IW : SW;

    logic          r_busy;
    logic [GW-1:0] r_grp;
    logic [PADW-1:0] w_pad;
    logic [IW-1:0] w_base;
    logic [G-1:0]  w_grp;
    logic [IW-1:0] w_idx_k;
    logic [IW-1:0] w_sel;
    logic          w_hit;
    logic          w_done;

    assign w_pad  = PADW'(i_flags);
    assign w_base = IW'({r_grp, {GB{1'b0}}});
    assign w_grp  = w_pad[w_base +: G];

    always_comb begin
        w_hit   = 1'b0;
        w_sel   = '0;
        w_idx_k = '0;
        // Walk downward so the lowest matching index wins.
        for (int k = G - 1; k >= 0; k--) begin
            w_idx_k = w_base | IW'(k);
            if (!w_grp[k] && (CMW'(w_idx_k) < CMW'(i_stored))) begin
                w_hit = 1'b1;
                w_sel = w_idx_k;
            end
        end
    end

    assign w_done = r_busy && (w_hit || (r_grp == GW'(NG - 1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_grp  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_grp  <= '0;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_grp <= r_grp + GW'(1);
        end
    end

    assign o_res.done  = w_done;
    assign o_res.found = w_hit;
    assign o_res.id    = SCAN_ID_W'(w_sel);
endmodule
